FILE: rtl/rc4_stream_cipher_assert.svh
// Assertion macros for the RC4 stream cipher checker.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RC4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher.
package rc4_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned BOX_DEPTH         = 256;
  localparam int unsigned BOX_AW            = 8;
  localparam int unsigned KEY_W             = 32;
  localparam int unsigned KEY_REG_BYTES     = KEY_W / BYTE_W;
  localparam int unsigned KEY_BYTES_DEFAULT = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [BOX_AW-1:0] box_addr_t;

  typedef struct packed {
    logic      rd_en;
    box_addr_t rd_addr;
    logic      wr_en;
    box_addr_t wr_addr;
    byte_t     wr_data;
  } mem_req_t;

  typedef struct packed {
    logic  valid;
    byte_t data;
  } res_t;

endpackage

FILE: rtl/rc4_sbox.sv
// Permutation memory: one write port, one read port with registered data.
module rc4_sbox
  import rc4_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output byte_t    rdata_o
);

  byte_t mem [BOX_DEPTH];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rc4_ctrl.sv
// Sequencer for key schedule and keystream steps over the permutation memory.
module rc4_ctrl
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  byte_t            data_byte_i,
  input  logic             start_i,
  output logic             in_stall_o,
  input  logic [KEY_W-1:0] key_i,
  output mem_req_t         mem_req_o,
  input  byte_t            mem_rdata_i,
  input  logic             out_free_i,
  output res_t             res_o
);

  localparam int unsigned KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX_RD,
    ST_MIX_J,
    ST_MIX_W1,
    ST_MIX_W2,
    ST_GEN_RD,
    ST_GEN_J,
    ST_GEN_W1,
    ST_GEN_W2,
    ST_GEN_OUT
  } state_e;

  state_e         state_q;
  box_addr_t      i_q;
  box_addr_t      j_q;
  box_addr_t      cnt_q;
  logic [KIW-1:0] kidx_q;
  logic           keyed_q;
  byte_t          si_q;
  byte_t          sj_q;
  byte_t          data_q;

  byte_t     key_bytes [KEY_BYTES];
  byte_t     cur_key;
  box_addr_t j_mix;
  box_addr_t j_gen;
  box_addr_t t_addr;
  byte_t     ks;
  logic      need_key;
  logic      cnt_last;

  for (genvar g = 0; g < KEY_BYTES; g++) begin : g_key
    if (g < KEY_REG_BYTES) begin : g_reg
      assign key_bytes[g] = key_i[BYTE_W*g +: BYTE_W];
    end else begin : g_zero
      assign key_bytes[g] = '0;
    end
  end

  assign cur_key  = key_bytes[kidx_q];
  assign j_mix    = j_q + mem_rdata_i + cur_key;
  assign j_gen    = j_q + mem_rdata_i;
  assign t_addr   = si_q + sj_q;
  assign need_key = start_i || !keyed_q;
  assign cnt_last = (cnt_q == box_addr_t'(BOX_DEPTH - 1));

  // s[j] is written in the same cycle that s[t] is read: forward it
  assign ks = (t_addr == j_q) ? si_q : mem_rdata_i;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    mem_req_o = '0;
    res_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !need_key) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = i_q + 1'b1;
        end
      end
      ST_INIT: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = cnt_q;
        mem_req_o.wr_data = cnt_q;
      end
      ST_MIX_RD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = cnt_q;
      end
      ST_MIX_J: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = j_mix;
      end
      ST_MIX_W1: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = cnt_q;
        mem_req_o.wr_data = mem_rdata_i;
      end
      ST_MIX_W2: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = j_q;
        mem_req_o.wr_data = si_q;
      end
      ST_GEN_RD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = i_q;
      end
      ST_GEN_J: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = j_gen;
      end
      ST_GEN_W1: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = i_q;
        mem_req_o.wr_data = mem_rdata_i;
      end
      ST_GEN_W2: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = j_q;
        mem_req_o.wr_data = si_q;
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = t_addr;
      end
      ST_GEN_OUT: begin
        res_o.valid = out_free_i;
        res_o.data  = data_q ^ ks;
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
      kidx_q  <= '0;
      keyed_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (need_key) begin
              cnt_q   <= '0;
              state_q <= ST_INIT;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_GEN_J;
            end
          end
        end
        ST_INIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_last) begin
            j_q     <= '0;
            kidx_q  <= '0;
            state_q <= ST_MIX_RD;
          end
        end
        ST_MIX_RD: begin
          state_q <= ST_MIX_J;
        end
        ST_MIX_J: begin
          j_q     <= j_mix;
          state_q <= ST_MIX_W1;
        end
        ST_MIX_W1: begin
          state_q <= ST_MIX_W2;
        end
        ST_MIX_W2: begin
          cnt_q  <= cnt_q + 1'b1;
          kidx_q <= (kidx_q == KIW'(KEY_BYTES - 1)) ? '0 : kidx_q + 1'b1;
          if (cnt_last) begin
            i_q     <= box_addr_t'(1);
            j_q     <= '0;
            keyed_q <= 1'b1;
            state_q <= ST_GEN_RD;
          end else begin
            state_q <= ST_MIX_RD;
          end
        end
        ST_GEN_RD: begin
          state_q <= ST_GEN_J;
        end
        ST_GEN_J: begin
          j_q     <= j_gen;
          state_q <= ST_GEN_W1;
        end
        ST_GEN_W1: begin
          state_q <= ST_GEN_W2;
        end
        ST_GEN_W2: begin
          state_q <= ST_GEN_OUT;
        end
        ST_GEN_OUT: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      data_q <= data_byte_i;
    end
    if (state_q == ST_MIX_J || state_q == ST_GEN_J) begin
      si_q <= mem_rdata_i;
    end
    if (state_q == ST_GEN_W1) begin
      sj_q <= mem_rdata_i;
    end
  end

endmodule

FILE: rtl/rc4_stream_cipher.sv
// RC4 stream cipher top level: key register, sequencer, permutation memory, output register.
//
// Each input byte is XORed with the next RC4 keystream byte, so the block both
// encrypts and decrypts. A byte with start_of_message set, or the first byte after
// reset, first runs the key schedule with the key register written over the
// configuration port (byte n at bits 8n+7..8n, used in turn over KEY_BYTES bytes,
// bytes past the fourth read as zero). A byte on a keyed stream steps through GEN_J,
// GEN_W1, GEN_W2 and GEN_OUT before the next acceptance, set by the read-modify-write
// of two permutation entries plus the keystream read on the single read port of the
// memory. The key schedule loads the identity into all 256 entries, mixes with two
// reads and two writes per entry and reads entry 1 again. A finished byte waits in
// the output register while the next byte is accepted. Write the key only while no
// byte is in flight; it takes effect at the next key schedule.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [KEY_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             start_of_message_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o
);

  logic [KEY_W-1:0] key_q;
  logic             out_valid_q;
  byte_t            out_byte_q;
  logic             out_free;
  mem_req_t         mem_req;
  byte_t            mem_rdata;
  res_t             res;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        key_q <= cfg_data_i;
      end
      if (out_free) begin
        out_valid_q <= res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_byte_q <= res.data;
    end
  end

  rc4_ctrl #(
    .KEY_BYTES(KEY_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .start_i     (start_of_message_i),
    .in_stall_o  (in_stall_o),
    .key_i       (key_q),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .out_free_i  (out_free),
    .res_o       (res)
  );

  rc4_sbox u_sbox (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

FILE: rtl/rc4_checker.sv
// Port-level assertions for the RC4 stream cipher, bound to the top level.
`include "rc4_stream_cipher_assert.svh"

module rc4_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o
);

  logic in_acc;
  logic out_held;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;

  `RC4_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "input not held off after item")
  `RC4_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_byte_o), "held item changed")
  `RC4_ASSERT_NOW(a_out_from_work, $rose(out_valid_o), $past(in_stall_o), "result without item")
  `RC4_ASSERT_NOW(a_done_gives_out, $fell(in_stall_o), out_valid_o, "item finished without result")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

FILE: tb/rc4_stream_cipher_test.sv
// Self-checking testbench for the RC4 stream cipher: keystream predictor, scoreboard, stimulus.
class rc4_keystream_scoreboard;
  localparam int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEFAULT;

  rc4_pkg::byte_t              sbox [rc4_pkg::BOX_DEPTH];
  rc4_pkg::box_addr_t          idx_i;
  rc4_pkg::box_addr_t          idx_j;
  bit                          keyed;
  logic [rc4_pkg::KEY_W-1:0]   key;
  rc4_pkg::byte_t              expected_bytes [$];
  int                          errors;

  function new();
    idx_i  = '0;
    idx_j  = '0;
    keyed  = 1'b0;
    key    = '0;
    errors = 0;
  endfunction

  function void set_key(logic [rc4_pkg::KEY_W-1:0] k);
    key = k;
  endfunction

  function rc4_pkg::byte_t key_byte_at(int n);
    int sel;
    sel = n % KEY_BYTES;
    if (sel >= rc4_pkg::KEY_REG_BYTES) return '0;
    return key[8*sel +: 8];
  endfunction

  function void run_key_schedule();
    rc4_pkg::byte_t jj;
    rc4_pkg::byte_t tmp;
    jj = '0;
    for (int n = 0; n < rc4_pkg::BOX_DEPTH; n++) sbox[n] = rc4_pkg::byte_t'(n);
    for (int n = 0; n < rc4_pkg::BOX_DEPTH; n++) begin
      jj       = jj + sbox[n] + key_byte_at(n);
      tmp      = sbox[n];
      sbox[n]  = sbox[jj];
      sbox[jj] = tmp;
    end
    idx_i = '0;
    idx_j = '0;
    keyed = 1'b1;
  endfunction

  function void note_input(rc4_pkg::byte_t data, bit start);
    rc4_pkg::byte_t tmp;
    rc4_pkg::byte_t ks_addr;
    if (start || !keyed) run_key_schedule();
    idx_i       = idx_i + 8'd1;
    idx_j       = idx_j + sbox[idx_i];
    tmp         = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = tmp;
    ks_addr     = sbox[idx_i] + sbox[idx_j];
    expected_bytes.push_back(data ^ sbox[ks_addr]);
  endfunction

  function void check_result(rc4_pkg::byte_t actual);
    rc4_pkg::byte_t exp_byte;
    if (expected_bytes.size() == 0) begin
      $error("out_byte: no item expected, actual %02h", actual);
      errors++;
      return;
    end
    exp_byte = expected_bytes.pop_front();
    if (actual !== exp_byte) begin
      $error("out_byte: expected %02h, actual %02h", exp_byte, actual);
      errors++;
    end
  endfunction
endclass

module rc4_stream_cipher_test;
  import rc4_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_BYTES   = KEY_BYTES_DEFAULT;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 150;
  localparam int          HOLD_AT     = 400;
  localparam int          HOLD_LEN    = 300;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [KEY_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       data_byte_i;
  logic             start_of_message_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       out_byte_o;

  rc4_keystream_scoreboard sb = new();
  int burst_left;

  rc4_stream_cipher #(.KEY_BYTES(KEY_BYTES)) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .start_of_message_i (start_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_byte_o         (out_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8ms;
    $display("rc4_stream_cipher_test failed");
    $finish;
  end

  // Receiver: stall pattern of its own, one long hold-off, result check.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int in_seen;
    bit hold_done;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    in_seen   = 0;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_byte_o);
      if (rst_ni && in_valid_i && !in_stall_o) in_seen++;
      if (!hold_done && in_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 2) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_byte(byte_t d, bit s);
    in_valid_i         <= 1'b1;
    data_byte_i        <= d;
    start_of_message_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(d, s);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_key(logic [KEY_W-1:0] k);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_key(k);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    bit               s;
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    data_byte_i        = '0;
    start_of_message_i = 1'b0;
    burst_left         = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first bytes after reset key the stream with the reset key, start flag low
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);

    // new key must not disturb the running stream until the next start
    write_key('1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    write_key(32'h0000_0001);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b0);

    write_key(32'h8000_0000);
    send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: k = '0;
        1: k = '1;
        default: k = {$urandom()};
      endcase
      write_key(k);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 0) s = ($urandom_range(0, 1) == 0);
        else        s = ($urandom_range(0, 29) == 0);
        send_byte(byte_t'($urandom_range(0, 255)), s);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("rc4_stream_cipher_test passed");
    end else begin
      $display("rc4_stream_cipher_test failed");
    end
    $finish;
  end
endmodule
